// ===== design/stable_priority_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue core
// Shared property shorthands: same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared types, opcodes and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int PRIO_W    = 16;
    localparam int PAYLOAD_W = 32;
    localparam int OCC_W     = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One stored entry
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [PAYLOAD_W-1:0]     payload;
    } spq_entry_t;

    // Broadcast command to every cell
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [PRIO_W-1:0] prio;
        logic [PAYLOAD_W-1:0]     payload;
    } spq_cmd_t;

endpackage

// ===== design/spq_in_if.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue input channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spq_in_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [PRIO_W-1:0] prio_in;
    logic [PAYLOAD_W-1:0]     payload_in;

    modport source (output valid, output opcode, output prio_in, output payload_in,
                    input ready);
    modport sink   (input valid, input opcode, input prio_in, input payload_in,
                    output ready);
endinterface

// ===== design/spq_out_if.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue output channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spq_out_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [PRIO_W-1:0] prio_out;
    logic [PAYLOAD_W-1:0]     payload_out;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output prio_out, output payload_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input prio_out, input payload_out,
                    input occupancy, output ready);
endinterface

// ===== design/stable_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue core
// Sorted array of DEPTH cells; enqueue inserts in place, dequeue pops front.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake     | word
//   --------+-----+---------------+-------------------------------------------
//   in_ch   | in  | valid/ready   | opcode, prio_in, payload_in
//   out_ch  | out | valid/ready   | status, prio_out, payload_out, occupancy
//
// For each accepted word, all cells compare against the new
// priority in parallel and shift by one place toward the back (enqueue) or
// the front (dequeue) at the same clock edge.
// The result appears in the output register in the cycle after acceptance.
// A new word is accepted while the result register is empty or being drained,
// so the block sustains one word per cycle when out_ch does not stall.
// Reset clears the fill count and the result valid flag; the cell contents
// are meaningless until written and are never read beyond the fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stable_priority_queue_core_macros.svh"

module stable_priority_queue_core #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    spq_in_if.sink   in_ch,
    spq_out_if.source out_ch
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fill count and result register
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    status_t                  status_reg;
    logic signed [PRIO_W-1:0] prio_reg;
    logic [PAYLOAD_W-1:0]     payload_reg;
    logic [OCC_W-1:0]         occ_reg;

    // Result of the current word
    status_t                  res_status;
    logic signed [PRIO_W-1:0] res_prio;
    logic [PAYLOAD_W-1:0]     res_payload;

    logic       accept;
    spq_cmd_t   cmd;
    spq_entry_t cell_data [DEPTH];
    logic       cell_keep [DEPTH];

    // Take a word whenever the result register is free or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Decode the word; only effective operations reach the cells
    always_comb
    begin
        cmd         = '0;
        cmd.prio    = in_ch.prio_in;
        cmd.payload = in_ch.payload_in;
        count_next  = count_reg;
        res_status  = ST_OK;
        res_prio    = '0;
        res_payload = '0;
        if (accept)
        begin
            case (in_ch.opcode)
                OP_ENQ:
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.enq    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_DEQ:
                begin
                    if (count_reg == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        // Front cell holds the highest, oldest entry
                        cmd.deq     = 1'b1;
                        res_prio    = cell_data[0].prio;
                        res_payload = cell_data[0].payload;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // Cell chain: each cell sees its neighbors and the broadcast command
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic       left_keep;
        spq_entry_t left;
        spq_entry_t right;

        if (i == 0)
        begin : g_front
            assign left_keep = 1'b1;
            assign left      = '0;
        end
        else
        begin : g_mid
            assign left_keep = cell_keep[i-1];
            assign left      = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign right = cell_data[i];
        end
        else
        begin : g_inner
            assign right = cell_data[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .valid     (count_reg > CNT_W'(i)),
            .left_keep (left_keep),
            .left      (left),
            .right     (right),
            .entry     (cell_data[i]),
            .keep      (cell_keep[i])
        );
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= res_status;
            prio_reg    <= res_prio;
            payload_reg <= res_payload;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.prio_out    = prio_reg;
    assign out_ch.payload_out = payload_reg;
    assign out_ch.occupancy   = occ_reg;

    // Checks
    `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SPQ_ASSERT_NOW(a_front_sorted, clk, rst_n, count_reg >= CNT_W'(2),
        cell_data[0].prio >= cell_data[1].prio)
    `SPQ_ASSERT_NEXT(a_deq_pop, clk, rst_n,
        accept && in_ch.opcode == OP_DEQ && count_reg != '0,
        out_ch.status == ST_OK && count_reg == $past(count_reg) - CNT_W'(1))
    `SPQ_ASSERT_NEXT(a_enq_full, clk, rst_n,
        accept && in_ch.opcode == OP_ENQ && count_reg == CNT_W'(DEPTH),
        out_ch.status == ST_FULL && $stable(count_reg))

endmodule

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted array: hold, take the new word, or shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
    input  logic              clk,
    input  spq_pkg::spq_cmd_t cmd,
    input  logic              valid,
    input  logic              left_keep,
    input  spq_pkg::spq_entry_t left,
    input  spq_pkg::spq_entry_t right,
    output spq_pkg::spq_entry_t entry,
    output logic              keep
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // Valid slot at equal or higher priority stays ahead of the new word
    assign keep  = valid && (entry_reg.prio >= cmd.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.enq)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    entry_next.prio    = cmd.prio;
                    entry_next.payload = cmd.payload;
                end
                else
                begin
                    entry_next = left;
                end
            end
        end
        else if (cmd.deq)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== bench/stable_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue core testbench
// Drives enqueue and dequeue words through the input channel and checks each
// result word against a sorted-store predictor that runs in the testbench.
// A short directed opening is followed by random fill, drain and mixed
// phases. The sender works in random bursts. The receiver stalls on its own
// pattern and holds off twice for a long stretch.
// ----------------------------------------------------------------------------

module stable_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int          RANDOM_OPS   = 800;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 10;

    // One operation word as offered on the input channel
    typedef struct packed {
        logic                     opcode;
        logic signed [PRIO_W-1:0] prio;
        logic [PAYLOAD_W-1:0]     payload;
    } queue_op_t;

    // One result word as it should appear on the output channel
    typedef struct packed {
        status_t                  status;
        logic signed [PRIO_W-1:0] prio;
        logic [PAYLOAD_W-1:0]     payload;
        logic [OCC_W-1:0]         occupancy;
    } queue_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    stable_priority_queue_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a sorted copy of the store, front at slot 0
    // ------------------------------------------------------------------------
    logic signed [PRIO_W-1:0] slot_prio    [SPQ_DEPTH];
    logic [PAYLOAD_W-1:0]     slot_payload [SPQ_DEPTH];
    int unsigned              slot_fill = 0;

    queue_op_t     pending_ops[$];
    queue_result_t awaited_results[$];

    int unsigned words_in      = 0;
    int unsigned words_out     = 0;
    int unsigned total_ops     = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    logic        word_taken    = 1'b0;

    // Sender burst state
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    // Receiver stall pattern and long hold-off
    int unsigned rx_mode    = 0;
    int unsigned rx_seg     = 0;
    int unsigned rx_phase   = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_mark  = 200;
    int unsigned hold_count = 0;

    // Insert behind every entry of equal or higher priority, or pop the
    // front; push the result word this operation should produce.
    function automatic void predict_queue_op(input queue_op_t op);
        queue_result_t res;
        int unsigned   pos;
        res = '{status: ST_OK, prio: '0, payload: '0, occupancy: '0};
        if (op.opcode == OP_ENQ)
        begin
            if (slot_fill >= SPQ_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < slot_fill && slot_prio[pos] >= op.prio)
                    pos++;
                for (int k = slot_fill; k > pos; k--)
                begin
                    slot_prio[k]    = slot_prio[k-1];
                    slot_payload[k] = slot_payload[k-1];
                end
                slot_prio[pos]    = op.prio;
                slot_payload[pos] = op.payload;
                slot_fill++;
            end
        end
        else
        begin
            if (slot_fill == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.prio    = slot_prio[0];
                res.payload = slot_payload[0];
                for (int k = 1; k < slot_fill; k++)
                begin
                    slot_prio[k-1]    = slot_prio[k];
                    slot_payload[k-1] = slot_payload[k];
                end
                slot_fill--;
            end
        end
        res.occupancy = slot_fill[OCC_W-1:0];
        awaited_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h, want %h", words_out, field, got, want);
        mismatches++;
    endtask

    task automatic add_enq(input logic signed [PRIO_W-1:0] prio,
                           input logic [PAYLOAD_W-1:0] payload);
        pending_ops.push_back('{opcode: OP_ENQ, prio: prio, payload: payload});
    endtask

    // Prio and payload of a dequeue are don't-care; fill them with noise
    task automatic add_deq();
        pending_ops.push_back('{opcode: OP_DEQ, prio: 16'($urandom), payload: $urandom});
    endtask

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        logic signed [PRIO_W-1:0] p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: p = 16'(int'($urandom_range(0, 8)) - 4);  // dense ties
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       p = 16'sh7fff;
                    1:       p = 16'sh8000;
                    2:       p = 16'sh0000;
                    default: p = 16'shffff;
                endcase
            end
            default: p = 16'($urandom_range(0, 65535));
        endcase
        return p;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            word_taken <= in_ch.valid && in_ch.ready;

            // Check the output word against the oldest awaited result
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unexpected word", {30'd0, out_ch.status}, '0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_ch.status !== want.status)
                        report_mismatch("status", {30'd0, out_ch.status},
                                        {30'd0, want.status});
                    if (out_ch.prio_out !== want.prio)
                        report_mismatch("prio_out", {16'd0, out_ch.prio_out},
                                        {16'd0, want.prio});
                    if (out_ch.payload_out !== want.payload)
                        report_mismatch("payload_out", out_ch.payload_out, want.payload);
                    if (out_ch.occupancy !== want.occupancy)
                        report_mismatch("occupancy", {27'd0, out_ch.occupancy},
                                        {27'd0, want.occupancy});
                end
                words_out <= words_out + 1;
            end

            // Advance the predictor on every accepted input word
            if (in_ch.valid && in_ch.ready)
            begin
                predict_queue_op('{opcode: in_ch.opcode, prio: in_ch.prio_in,
                                   payload: in_ch.payload_in});
                words_in <= words_in + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offer words at the falling edge in bursts with random gaps.
    // Hold the current word until it is taken.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        queue_op_t nxt;
        if (rst_n && !(in_ch.valid && !word_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                nxt = pending_ops.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.opcode     <= nxt.opcode;
                in_ch.prio_in    <= nxt.prio;
                in_ch.payload_in <= nxt.payload;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 30);
                    // Some bursts run back to back with no gap at all
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long hold-off: counted here, on its own, after a number of words has
    // gone in. The sender keeps offering, so the result register fills and
    // the block drops ready on the input side.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (hold_count < 2 && words_in >= hold_mark)
            begin
                hold_left  <= HOLD_CYCLES;
                hold_count <= hold_count + 1;
                hold_mark  <= hold_mark + 350;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows segments of always-ready, coin-flip and
    // one-in-three patterns, and drops for the whole hold-off.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic rdy;
        if (rx_seg == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_seg  = $urandom_range(8, 60);
        end
        rx_seg--;
        rx_phase++;
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            default: rdy = (rx_phase % 3 == 0);
        endcase
        if (!rst_n || hold_left != 0)
            rdy = 1'b0;
        out_ch.ready <= rdy;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned made;
        int unsigned run_len;
        int unsigned enq_pct;

        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_ENQ;
        in_ch.prio_in    = '0;
        in_ch.payload_in = '0;
        out_ch.ready     = 1'b0;

        // Directed opening: dequeue from empty, fill to full with extreme
        // and tied priorities, enqueue into a full store, then pop some.
        add_deq();
        add_enq(16'sh7fff, 32'h0000_0000);
        add_enq(16'sh8000, 32'hffff_ffff);
        add_enq(16'sh0000, 32'h0000_0001);
        add_enq(16'shffff, 32'h8000_0000);
        add_enq(16'sh0001, 32'h5555_5555);
        add_enq(16'sh0005, 32'haaaa_aaaa);
        add_enq(16'sh0005, 32'h0000_0005);
        add_enq(16'sh0005, 32'h0000_0006);
        add_enq(16'sh8000, 32'h1234_5678);
        add_enq(16'sh7fff, 32'h7fff_ffff);
        add_enq(16'sh0064, 32'h0000_0064);
        add_enq(16'sh0064, 32'h0000_0065);
        add_enq(16'shff9c, 32'hdead_beef);
        add_enq(16'sh0000, 32'h0000_0002);
        add_enq(16'sh0007, 32'hcafe_f00d);
        add_enq(16'sh0007, 32'h0000_0007);
        add_enq(16'sh7fff, 32'hffff_fffe);
        repeat (6) add_deq();

        // Random phases: fill-heavy runs push into the full case, drain-heavy
        // runs empty the store, balanced runs churn the middle.
        made = 0;
        while (made < RANDOM_OPS)
        begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            run_len = $urandom_range(10, 40);
            repeat (run_len)
            begin
                if ($urandom_range(1, 100) <= enq_pct)
                    add_enq(pick_prio(), pick_payload());
                else
                    add_deq();
                made++;
            end
        end
        total_ops = pending_ops.size();

        // Hold reset, then release it away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_in < total_ops)
            @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
        // Let any stray word surface before the verdict
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
